/* design/ccb_pkg.sv */
// Shared types and constants for the text console cell buffer.
`timescale 1ns / 1ps

package ccb_pkg;

    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int ROW_W  = 4;
    localparam int COL_W  = 6;

    localparam logic [OP_W-1:0] OP_KEY   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_PUT,
        CMD_NEWLINE,
        CMD_BACKSPACE,
        CMD_CLEAR,
        CMD_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
        logic              read_ok;
    } cmd_t;

endpackage

/* design/ccb_front.sv */
// Front end: accepts input beats and classifies them into commands.
`timescale 1ns / 1ps

module ccb_front #(
    parameter int ROWS = 16,
    parameter int COLS = 46
) (
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ccb_pkg::OP_W-1:0]    s_op,
    input  logic [ccb_pkg::CHAR_W-1:0]  s_char_code,
    input  logic [ccb_pkg::ROW_W-1:0]   s_read_row,
    input  logic [ccb_pkg::COL_W-1:0]   s_read_col,
    input  logic                        init_busy,
    output logic                        cmd_valid,
    input  logic                        cmd_ready,
    output ccb_pkg::cmd_t               cmd
);
    import ccb_pkg::*;

    assign s_ready   = cmd_ready && !init_busy;
    assign cmd_valid = s_valid && !init_busy;

    always_comb begin
        cmd.char_code = s_char_code;
        cmd.read_row  = s_read_row;
        cmd.read_col  = s_read_col;
        cmd.read_ok   = (32'(s_read_row) < ROWS) && (32'(s_read_col) < COLS);
        unique case (s_op)
            OP_KEY: begin
                if (s_char_code == CH_CR || s_char_code == CH_LF) begin
                    cmd.kind = CMD_NEWLINE;
                end else if (s_char_code == CH_BS) begin
                    cmd.kind = CMD_BACKSPACE;
                end else begin
                    cmd.kind = CMD_PUT;
                end
            end
            OP_CLEAR: cmd.kind = CMD_CLEAR;
            OP_READ:  cmd.kind = CMD_READ;
            default:  cmd.kind = CMD_NOP;
        endcase
    end

endmodule

/* design/ccb_fifo.sv */
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps

module ccb_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  ccb_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output ccb_pkg::cmd_t pop_data
);
    import ccb_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push_fire, pop_fire;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push_fire ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_fire ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire && !pop_fire) begin
            count_next = count_reg + 2'd1;
        end else if (pop_fire && !push_fire) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* design/ccb_back.sv */
// Back end: cursor, ring row offset, cell memory, fill sweeps and result register.
`timescale 1ns / 1ps

module ccb_back #(
    parameter int ROWS = 16,
    parameter int COLS = 46
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  ccb_pkg::cmd_t               cmd,
    output logic                        init_busy,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_cell_written,
    output logic [ccb_pkg::ROW_W-1:0]   m_write_row,
    output logic [ccb_pkg::COL_W-1:0]   m_write_col,
    output logic [ccb_pkg::CHAR_W-1:0]  m_write_char,
    output logic                        m_scrolled,
    output logic [ccb_pkg::ROW_W-1:0]   m_cursor_row_out,
    output logic [ccb_pkg::COL_W-1:0]   m_cursor_col_out,
    output logic [ccb_pkg::CHAR_W-1:0]  m_read_char
);
    import ccb_pkg::*;

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int CCW   = $clog2(COLS + 1);
    localparam int AW    = RW + CW;
    localparam int DEPTH = ROWS << CW;
    localparam logic [RW:0]    ROWS_X   = (RW + 1)'(ROWS);
    localparam logic [RW-1:0]  LAST_ROW = RW'(ROWS - 1);
    localparam logic [CW-1:0]  LAST_COL = CW'(COLS - 1);
    localparam logic [CCW-1:0] FULL_COL = CCW'(COLS);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_FILL_ALL,
        S_FILL_ROW,
        S_PUT
    } state_t;

    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] top,
                                               input logic [RW-1:0] vrow);
        logic [RW:0] sum;
        sum = {1'b0, top} + {1'b0, vrow};
        if (sum >= ROWS_X) begin
            sum = sum - ROWS_X;
        end
        return sum[RW-1:0];
    endfunction

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rdata_reg;

    state_t            state_reg, state_next;
    logic [RW-1:0]     cur_row_reg, cur_row_next;
    logic [CCW-1:0]    cur_col_reg, cur_col_next;
    logic [RW-1:0]     top_reg, top_next;
    logic [RW-1:0]     fill_row_reg, fill_row_next;
    logic [CW-1:0]     fill_col_reg, fill_col_next;
    logic [CHAR_W-1:0] put_char_reg, put_char_next;
    logic              pend_put_reg, pend_put_next;
    logic              scroll_reg, scroll_next;
    logic              read_ok_reg, read_ok_next;

    logic              m_valid_reg, m_valid_next;
    logic              written_reg, written_next;
    logic [ROW_W-1:0]  wrow_reg, wrow_next;
    logic [COL_W-1:0]  wcol_reg, wcol_next;
    logic [CHAR_W-1:0] wchar_reg, wchar_next;
    logic              scrolled_reg, scrolled_next;
    logic [ROW_W-1:0]  crow_reg, crow_next;
    logic [COL_W-1:0]  ccol_reg, ccol_next;
    logic [CHAR_W-1:0] rchar_reg, rchar_next;

    logic              emit, e_written, e_scrolled;
    logic [ROW_W-1:0]  e_wrow;
    logic [COL_W-1:0]  e_wcol;
    logic [CHAR_W-1:0] e_wchar, e_rchar;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [CHAR_W-1:0] mem_wdata;
    logic              slot_free, cmd_pop;
    logic [RW-1:0]     cur_prow;
    logic [CCW-1:0]    col_m1;

    assign slot_free = !m_valid_reg || m_ready;
    assign cmd_ready = (state_reg == S_IDLE) && slot_free;
    assign cmd_pop   = cmd_valid && cmd_ready;
    assign init_busy = (state_reg == S_INIT);
    assign cur_prow  = phys_row(top_reg, cur_row_reg);
    assign col_m1    = cur_col_reg - 1'b1;

    always_comb begin
        state_next    = state_reg;
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        top_next      = top_reg;
        fill_row_next = fill_row_reg;
        fill_col_next = fill_col_reg;
        put_char_next = put_char_reg;
        pend_put_next = pend_put_reg;
        scroll_next   = scroll_reg;
        read_ok_next  = read_ok_reg;

        emit       = 1'b0;
        e_written  = 1'b0;
        e_wrow     = '0;
        e_wcol     = '0;
        e_wchar    = '0;
        e_scrolled = 1'b0;
        e_rchar    = '0;

        mem_we    = 1'b0;
        mem_waddr = {fill_row_reg, fill_col_reg};
        mem_wdata = CH_SPACE;
        mem_raddr = '0;

        unique case (state_reg)
            S_INIT, S_FILL_ALL: begin
                mem_we = 1'b1;
                if (fill_col_reg == LAST_COL) begin
                    fill_col_next = '0;
                    if (fill_row_reg == LAST_ROW) begin
                        state_next = S_IDLE;
                        emit       = (state_reg == S_FILL_ALL);
                    end else begin
                        fill_row_next = fill_row_reg + 1'b1;
                    end
                end else begin
                    fill_col_next = fill_col_reg + 1'b1;
                end
            end
            S_FILL_ROW: begin
                mem_we = 1'b1;
                if (fill_col_reg == LAST_COL) begin
                    fill_col_next = '0;
                    if (pend_put_reg) begin
                        state_next = S_PUT;
                    end else begin
                        state_next = S_IDLE;
                        emit       = 1'b1;
                        e_scrolled = 1'b1;
                    end
                end else begin
                    fill_col_next = fill_col_reg + 1'b1;
                end
            end
            S_PUT: begin
                mem_we       = 1'b1;
                mem_waddr    = {cur_prow, cur_col_reg[CW-1:0]};
                mem_wdata    = put_char_reg;
                cur_col_next = cur_col_reg + 1'b1;
                state_next   = S_IDLE;
                emit         = 1'b1;
                e_written    = 1'b1;
                e_wrow       = ROW_W'(cur_row_reg);
                e_wcol       = COL_W'(cur_col_reg);
                e_wchar      = put_char_reg;
                e_scrolled   = scroll_reg;
            end
            S_READ: begin
                state_next = S_IDLE;
                emit       = 1'b1;
                e_rchar    = read_ok_reg ? rdata_reg : '0;
            end
            S_IDLE: begin
                if (cmd_pop) begin
                    unique case (cmd.kind)
                        CMD_READ: begin
                            read_ok_next = cmd.read_ok;
                            if (cmd.read_ok) begin
                                mem_raddr = {phys_row(top_reg, RW'(cmd.read_row)),
                                             CW'(cmd.read_col)};
                            end
                            state_next = S_READ;
                        end
                        CMD_CLEAR: begin
                            cur_row_next  = '0;
                            cur_col_next  = '0;
                            top_next      = '0;
                            fill_row_next = '0;
                            fill_col_next = '0;
                            state_next    = S_FILL_ALL;
                        end
                        CMD_NEWLINE: begin
                            cur_col_next = '0;
                            if (cur_row_reg == LAST_ROW) begin
                                top_next      = (top_reg == LAST_ROW) ? '0 : top_reg + 1'b1;
                                fill_row_next = top_reg;
                                fill_col_next = '0;
                                pend_put_next = 1'b0;
                                state_next    = S_FILL_ROW;
                            end else begin
                                cur_row_next = cur_row_reg + 1'b1;
                                emit         = 1'b1;
                            end
                        end
                        CMD_BACKSPACE: begin
                            emit = 1'b1;
                            if (cur_col_reg != '0) begin
                                mem_we       = 1'b1;
                                mem_waddr    = {cur_prow, col_m1[CW-1:0]};
                                mem_wdata    = CH_SPACE;
                                cur_col_next = col_m1;
                                e_written    = 1'b1;
                                e_wrow       = ROW_W'(cur_row_reg);
                                e_wcol       = COL_W'(col_m1);
                                e_wchar      = CH_SPACE;
                            end
                        end
                        CMD_PUT: begin
                            put_char_next = cmd.char_code;
                            scroll_next   = 1'b0;
                            state_next    = S_PUT;
                            if (cur_col_reg == FULL_COL) begin
                                cur_col_next = '0;
                                if (cur_row_reg == LAST_ROW) begin
                                    top_next      = (top_reg == LAST_ROW) ? '0 : top_reg + 1'b1;
                                    fill_row_next = top_reg;
                                    fill_col_next = '0;
                                    pend_put_next = 1'b1;
                                    scroll_next   = 1'b1;
                                    state_next    = S_FILL_ROW;
                                end else begin
                                    cur_row_next = cur_row_reg + 1'b1;
                                end
                            end
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        m_valid_next  = m_valid_reg && !m_ready;
        written_next  = written_reg;
        wrow_next     = wrow_reg;
        wcol_next     = wcol_reg;
        wchar_next    = wchar_reg;
        scrolled_next = scrolled_reg;
        crow_next     = crow_reg;
        ccol_next     = ccol_reg;
        rchar_next    = rchar_reg;
        if (emit) begin
            m_valid_next  = 1'b1;
            written_next  = e_written;
            wrow_next     = e_wrow;
            wcol_next     = e_wcol;
            wchar_next    = e_wchar;
            scrolled_next = e_scrolled;
            crow_next     = ROW_W'(cur_row_next);
            ccol_next     = COL_W'(cur_col_next);
            rchar_next    = e_rchar;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            cur_row_reg  <= '0;
            cur_col_reg  <= '0;
            top_reg      <= '0;
            fill_row_reg <= '0;
            fill_col_reg <= '0;
            pend_put_reg <= 1'b0;
            scroll_reg   <= 1'b0;
            read_ok_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_row_reg  <= cur_row_next;
            cur_col_reg  <= cur_col_next;
            top_reg      <= top_next;
            fill_row_reg <= fill_row_next;
            fill_col_reg <= fill_col_next;
            pend_put_reg <= pend_put_next;
            scroll_reg   <= scroll_next;
            read_ok_reg  <= read_ok_next;
            m_valid_reg  <= m_valid_next;
        end
        put_char_reg <= put_char_next;
        written_reg  <= written_next;
        wrow_reg     <= wrow_next;
        wcol_reg     <= wcol_next;
        wchar_reg    <= wchar_next;
        scrolled_reg <= scrolled_next;
        crow_reg     <= crow_next;
        ccol_reg     <= ccol_next;
        rchar_reg    <= rchar_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_cell_written   = written_reg;
    assign m_write_row      = wrow_reg;
    assign m_write_col      = wcol_reg;
    assign m_write_char     = wchar_reg;
    assign m_scrolled       = scrolled_reg;
    assign m_cursor_row_out = crow_reg;
    assign m_cursor_col_out = ccol_reg;
    assign m_read_char      = rchar_reg;

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_col_reg <= FULL_COL)
        else $error("Cursor column beyond a full row.");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_row_reg <= LAST_ROW && top_reg <= LAST_ROW)
        else $error("Cursor row or top row offset out of range.");

    a_scroll_bottom: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && scrolled_reg) |-> (crow_reg == ROW_W'(ROWS - 1)))
        else $error("Scroll reported with the cursor off the bottom row.");

    a_init_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INIT) |-> (!m_valid_reg && !cmd_pop))
        else $error("Activity during the clearing pass after reset.");

    a_pending_put: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FILL_ROW && pend_put_reg) |-> scroll_reg)
        else $error("Wrapped character after a scroll without the scroll flag.");

endmodule

/* design/text_console_cell_buffer.sv */
// Top level of the text console cell buffer: front end, command queue and back end.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    op, char_code, read_row, read_col
//   m_        out        m_valid/m_ready    one result beat per input beat
//
// After reset the cell memory is swept to spaces, one cell per cycle, over only
// the COLS used cells of each row; no beat is accepted until the sweep ends.
// The back end works on one command at a time: a character passes through S_PUT and a
// read through S_READ, a backspace or a newline without scroll finishes in S_IDLE, a
// scroll adds a fill sweep over the COLS cells of one row and a clear one over the used
// cells of every row, all through the single memory write port.
// The front end takes a beat every cycle while the two-entry queue has room, so it
// keeps accepting while a finished result waits in the output register.
`timescale 1ns / 1ps

module text_console_cell_buffer #(
    parameter int ROWS = 16,
    parameter int COLS = 46
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ccb_pkg::OP_W-1:0]    s_op,
    input  logic [ccb_pkg::CHAR_W-1:0]  s_char_code,
    input  logic [ccb_pkg::ROW_W-1:0]   s_read_row,
    input  logic [ccb_pkg::COL_W-1:0]   s_read_col,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_cell_written,
    output logic [ccb_pkg::ROW_W-1:0]   m_write_row,
    output logic [ccb_pkg::COL_W-1:0]   m_write_col,
    output logic [ccb_pkg::CHAR_W-1:0]  m_write_char,
    output logic                        m_scrolled,
    output logic [ccb_pkg::ROW_W-1:0]   m_cursor_row_out,
    output logic [ccb_pkg::COL_W-1:0]   m_cursor_col_out,
    output logic [ccb_pkg::CHAR_W-1:0]  m_read_char
);
    import ccb_pkg::*;

    cmd_t front_cmd, queue_cmd;
    logic front_valid, queue_ready, queue_valid, back_ready, init_busy;

    ccb_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_char_code (s_char_code),
        .s_read_row  (s_read_row),
        .s_read_col  (s_read_col),
        .init_busy   (init_busy),
        .cmd_valid   (front_valid),
        .cmd_ready   (queue_ready),
        .cmd         (front_cmd)
    );

    ccb_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (queue_ready),
        .push_data  (front_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (back_ready),
        .pop_data   (queue_cmd)
    );

    ccb_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd_valid        (queue_valid),
        .cmd_ready        (back_ready),
        .cmd              (queue_cmd),
        .init_busy        (init_busy),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cell_written   (m_cell_written),
        .m_write_row      (m_write_row),
        .m_write_col      (m_write_col),
        .m_write_char     (m_write_char),
        .m_scrolled       (m_scrolled),
        .m_cursor_row_out (m_cursor_row_out),
        .m_cursor_col_out (m_cursor_col_out),
        .m_read_char      (m_read_char)
    );

endmodule
